FILE: sv/kmde_pkg.sv
// Shared types, constants and code tables for the key matrix debounce encoder.
// Used by kmde_state_ram, kmde_scan_engine and key_matrix_debounce_encoder_top.
`default_nettype none

package kmde_pkg;

   localparam int KEY_COUNT    = 64;
   localparam int KEY_IDX_W    = 6;
   localparam int TIME_W       = 32;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

   // modifier override keys and the modifier bits they force
   localparam logic [KEY_IDX_W-1:0] OVR_KEY_HI  = 6'd52;
   localparam logic [KEY_IDX_W-1:0] OVR_KEY_MID = 6'd11;
   localparam logic [KEY_IDX_W-1:0] OVR_KEY_LO  = 6'd5;
   localparam logic [7:0] OVR_MOD_HI  = 8'h40;
   localparam logic [7:0] OVR_MOD_MID = 8'h02;
   localparam logic [7:0] OVR_MOD_LO  = 8'h01;

   // CSR register indexes
   localparam logic CSR_DEBOUNCE = 1'b0;

   typedef logic [KEY_IDX_W-1:0] key_idx_type;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic              prev;
      logic              stable;
   } ram_entry_type;

   typedef struct packed {
      logic          rd_en;
      key_idx_type   rd_addr;
      logic          wr_en;
      key_idx_type   wr_addr;
      ram_entry_type wr_data;
   } ram_req_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } scan_state_type;

   localparam logic [7:0] KEYCODE_ROM [KEY_COUNT] = '{
      8'h1E, 8'h29, 8'h2B, 8'h29, 8'h2C, 8'hE0, 8'h14, 8'h1F,
      8'h20, 8'h1A, 8'h04, 8'h02, 8'h1D, 8'h16, 8'h08, 8'h21,
      8'h22, 8'h15, 8'h07, 8'h1B, 8'h06, 8'h09, 8'h17, 8'h23,
      8'h24, 8'h1C, 8'h0A, 8'h19, 8'h05, 8'h0B, 8'h18, 8'h25,
      8'h26, 8'h0C, 8'h0D, 8'h11, 8'h10, 8'h0E, 8'h12, 8'h27,
      8'h56, 8'h13, 8'h0F, 8'h36, 8'h37, 8'h33, 8'h2F, 8'h27,
      8'h31, 8'h1F, 8'h34, 8'h24, 8'hE5, 8'h2D, 8'h52, 8'h4A,
      8'h2A, 8'h28, 8'h50, 8'h52, 8'h3A, 8'h3C, 8'h3E, 8'h40
   };

   localparam logic [7:0] MODIFIER_ROM [KEY_COUNT] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
      8'h02, 8'h40, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

endpackage

`default_nettype wire

FILE: sv/key_matrix_debounce_encoder_top.sv
// Top level of the key matrix debounce encoder: CSR port and scan engine.
// Depends on kmde_pkg and kmde_scan_engine (which holds kmde_state_ram).
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   req      | req_valid / req_ready      | req_time_ms[31:0], req_key_levels[63:0]
//   rsp      | rsp_valid / rsp_ready      | rsp_modifier, rsp_keycode,
//            |                            | rsp_key_index, rsp_last
//   csr      | APB, csr_pready tied high  | debounce_ms at byte address 0
//
// When the result side keeps up, the sequencer visits one key per cycle through
// the single read port and single write port of the per-key state memory.
// A report waits in a hold register until the next one (or scan end) settles
// its last flag; a stalled result channel stops the key walk in place.
// Reset is synchronous; the state memory reads as zero until each key is
// first written, so no clearing pass is needed. debounce_ms resets to 10.
`default_nettype none

module key_matrix_debounce_encoder_top #(
   parameter int NUM_ROWS = 8,
   parameter int NUM_COLS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // scan transactions
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [31:0] req_time_ms,
   input  wire logic [63:0] req_key_levels,
   // report transactions
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_modifier,
   output      logic [7:0]  rsp_keycode,
   output      logic [5:0]  rsp_key_index,
   output      logic        rsp_last,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   import kmde_pkg::*;

   logic [7:0] debounce_ms_ff, debounce_ms_in;
   logic       csr_write;
   logic       csr_hit;

   // word index is paddr[2]; only word 0 exists
   assign csr_hit    = (csr_paddr[2] == CSR_DEBOUNCE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      debounce_ms_in = debounce_ms_ff;
      if (csr_write && csr_hit) begin
         debounce_ms_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_RESET;
      end else begin
         debounce_ms_ff <= debounce_ms_in;
      end
   end

   assign csr_prdata = csr_hit ? {24'd0, debounce_ms_ff} : 32'd0;

   kmde_scan_engine #(
      .NUM_ROWS (NUM_ROWS),
      .NUM_COLS (NUM_COLS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .debounce_ms    (debounce_ms_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_time_ms    (req_time_ms),
      .req_key_levels (req_key_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_modifier   (rsp_modifier),
      .rsp_keycode    (rsp_keycode),
      .rsp_key_index  (rsp_key_index),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

FILE: sv/kmde_state_ram.sv
// Per-key state memory: change stamp, previous sample and stable level.
// One read and one write port, registered read; valid bits give reset zeros.
// Depends on kmde_pkg.
`default_nettype none

module kmde_state_ram (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kmde_pkg::ram_req_type ram_req,
   output      kmde_pkg::ram_entry_type rd_entry
);
   import kmde_pkg::*;

   ram_entry_type          mem [KEY_COUNT];
   logic [KEY_COUNT-1:0]   valid_ff;
   logic [KEY_COUNT-1:0]   valid_in;
   ram_entry_type          rd_data_ff;
   logic                   rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ram_req.wr_en) begin
         valid_in[ram_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ram_req.rd_en) begin
            rd_valid_ff <= valid_ff[ram_req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   // never-written entries read as all zero
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: sv/kmde_scan_engine.sv
// Scan sequencer: walks the keys, does read-modify-write on the state memory,
// debounces, encodes reports and drives the result channel.
// Depends on kmde_pkg and kmde_state_ram.
`default_nettype none

module kmde_scan_engine #(
   parameter int NUM_ROWS = 8,
   parameter int NUM_COLS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  debounce_ms,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [31:0] req_time_ms,
   input  wire logic [63:0] req_key_levels,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_modifier,
   output      logic [7:0]  rsp_keycode,
   output      logic [5:0]  rsp_key_index,
   output      logic        rsp_last
);
   import kmde_pkg::*;

   localparam logic [2:0] LAST_ROW = 3'(NUM_ROWS - 1);
   localparam logic [2:0] LAST_COL = 3'(NUM_COLS - 1);

   scan_state_type    state_ff, state_in;
   logic [2:0]        row_ff, row_in, col_ff, col_in;
   logic              issue_done_ff, issue_done_in;
   logic              s1_valid_ff, s1_valid_in;
   key_idx_type       s1_key_ff, s1_key_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [63:0]       levels_ff, levels_in;
   logic [7:0]        ovr_ff, ovr_in;

   logic              hold_valid_ff, hold_valid_in;
   logic [7:0]        hold_mod_ff, hold_mod_in;
   logic [7:0]        hold_code_ff, hold_code_in;
   key_idx_type       hold_idx_ff, hold_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_mod_ff, rsp_mod_in;
   logic [7:0]        rsp_code_ff, rsp_code_in;
   key_idx_type       rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   ram_req_type       ram_req;
   ram_entry_type     rd_entry;
   ram_entry_type     wr_entry;

   logic              accept, lvl, changed, fire, slot_free, s1_go, advance, issue;
   logic              last_key;
   logic [TIME_W-1:0] stamp_new, age;
   logic [7:0]        new_mod, new_code;

   kmde_state_ram u_ram (
      .clock    (clock),
      .reset    (reset),
      .ram_req  (ram_req),
      .rd_entry (rd_entry)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // debounce of the key whose state just came back from memory
   always_comb begin
      lvl       = levels_ff[s1_key_ff];
      changed   = (lvl != rd_entry.prev);
      stamp_new = changed ? time_ff : rd_entry.stamp;
      age       = time_ff - stamp_new;
      fire      = (age > {24'd0, debounce_ms}) && (rd_entry.prev != rd_entry.stable);
      wr_entry.stamp  = stamp_new;
      wr_entry.prev   = lvl;
      wr_entry.stable = fire ? rd_entry.prev : rd_entry.stable;
      if (rd_entry.prev) begin
         new_mod  = 8'd0;
         new_code = 8'd0;
      end else begin
         new_mod  = (ovr_ff != 8'd0) ? ovr_ff : MODIFIER_ROM[s1_key_ff];
         new_code = KEYCODE_ROM[s1_key_ff];
      end
   end

   assign s1_go    = s1_valid_ff && (!fire || !hold_valid_ff || slot_free);
   assign advance  = !s1_valid_ff || s1_go;
   assign issue    = (state_ff == ST_SCAN) && advance && !issue_done_ff;
   assign last_key = (row_ff == LAST_ROW) && (col_ff == LAST_COL);

   always_comb begin
      ram_req.rd_en   = issue;
      ram_req.rd_addr = {row_ff, col_ff};
      ram_req.wr_en   = s1_go;
      ram_req.wr_addr = s1_key_ff;
      ram_req.wr_data = wr_entry;
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      issue_done_in = issue_done_ff;
      s1_valid_in   = s1_valid_ff;
      s1_key_in     = s1_key_ff;
      time_in       = time_ff;
      levels_in     = levels_ff;
      ovr_in        = ovr_ff;
      hold_valid_in = hold_valid_ff;
      hold_mod_in   = hold_mod_ff;
      hold_code_in  = hold_code_ff;
      hold_idx_in   = hold_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mod_in    = rsp_mod_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               time_in       = req_time_ms;
               levels_in     = req_key_levels;
               row_in        = 3'd0;
               col_in        = 3'd0;
               issue_done_in = 1'b0;
               state_in      = ST_SCAN;
               if (!req_key_levels[OVR_KEY_HI]) begin
                  ovr_in = OVR_MOD_HI;
               end else if (!req_key_levels[OVR_KEY_MID]) begin
                  ovr_in = OVR_MOD_MID;
               end else if (!req_key_levels[OVR_KEY_LO]) begin
                  ovr_in = OVR_MOD_LO;
               end else begin
                  ovr_in = 8'd0;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               s1_key_in = {row_ff, col_ff};
               if (last_key) begin
                  issue_done_in = 1'b1;
               end else if (col_ff == LAST_COL) begin
                  col_in = 3'd0;
                  row_in = row_ff + 3'd1;
               end else begin
                  col_in = col_ff + 3'd1;
               end
            end
            s1_valid_in = issue || (s1_valid_ff && !s1_go);

            if (s1_go && fire) begin
               // held report is not the last one: send it on
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_mod_in   = hold_mod_ff;
                  rsp_code_in  = hold_code_ff;
                  rsp_idx_in   = hold_idx_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_mod_in   = new_mod;
               hold_code_in  = new_code;
               hold_idx_in   = s1_key_ff;
            end

            // scan complete: flush the held report flagged as last
            if (issue_done_ff && !s1_valid_ff) begin
               if (!hold_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (slot_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_mod_in    = hold_mod_ff;
                  rsp_code_in   = hold_code_ff;
                  rsp_idx_in    = hold_idx_ff;
                  rsp_last_in   = 1'b1;
                  hold_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b1;
         s1_valid_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         s1_valid_ff   <= s1_valid_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      s1_key_ff    <= s1_key_in;
      time_ff      <= time_in;
      levels_ff    <= levels_in;
      ovr_ff       <= ovr_in;
      hold_mod_ff  <= hold_mod_in;
      hold_code_ff <= hold_code_in;
      hold_idx_ff  <= hold_idx_in;
      rsp_mod_ff   <= rsp_mod_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_modifier  = rsp_mod_ff;
   assign rsp_keycode   = rsp_code_ff;
   assign rsp_key_index = rsp_idx_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire
